@@ rtl/core/uerp_pkg.sv @@
package uerp_pkg;

    // Field widths
    localparam int PULSE_W    = 16;
    localparam int DIST_W     = 14;
    localparam int PCT_W      = 8;
    localparam int CFG_DATA_W = 16;

    // Default sizing of the block
    localparam int RING_DEPTH_DEF = 8;
    localparam int WIDTH_BITS_DEF = 16;

    // Percent scale used by the presence and grade compares.
    localparam int PCT_SCALE = 100;

    // Distance in 1/16 inch: width*16/148 = width*4/37 for the round trip,
    // width*16/74 = width*8/37 for a one-way path. The division by 37 is a
    // multiply by a rounded-up reciprocal, exact for dividends below 2^20.
    localparam int  ROUND_TRIP_DIV = 148;
    localparam int  ONE_WAY_DIV    = 74;
    localparam int  DIV_BASE       = ONE_WAY_DIV / 2;
    localparam int  DIV_SHIFT      = 26;
    localparam int  DIV_MUL_W      = 21;
    localparam longint DIV_MUL_L   = ((longint'(1) << DIV_SHIFT) + DIV_BASE - 1) / DIV_BASE;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ACTIVE             = 3'd0,
        REG_TIMEOUT_US         = 3'd1,
        REG_DOUBLE_PATH        = 3'd2,
        REG_OBSTACLE_THRESHOLD = 3'd3,
        REG_PRESENCE_THRESHOLD = 3'd4,
        REG_PRESENCE_PERCENT   = 3'd5,
        REG_STRONG_PERCENT     = 3'd6,
        REG_WEAK_PERCENT       = 3'd7
    } cfg_index_t;

    // Presence grade codes
    typedef enum logic [1:0] {
        GRADE_NONE     = 2'd0,
        GRADE_WEAK     = 2'd1,
        GRADE_MODERATE = 2'd2,
        GRADE_STRONG   = 2'd3
    } grade_t;

    typedef struct packed {
        logic               active;
        logic [PULSE_W-1:0] timeout_us;
        logic               double_path;
        logic [DIST_W-1:0]  obstacle_threshold;
        logic [DIST_W-1:0]  presence_threshold;
        logic [PCT_W-1:0]   presence_percent;
        logic [PCT_W-1:0]   strong_percent;
        logic [PCT_W-1:0]   weak_percent;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        active:             1'b1,
        timeout_us:         16'd38000,
        double_path:        1'b0,
        obstacle_threshold: 14'd192,
        presence_threshold: 14'd0,
        presence_percent:   8'd10,
        strong_percent:     8'd10,
        weak_percent:       8'd5
    };

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width_us;
        logic               wait_ok;
    } in_t;

    typedef struct packed {
        logic              accepted;
        logic [DIST_W-1:0] latest_distance;
        logic [DIST_W-1:0] ring_average;
        logic              obstacle;
        logic              presence;
        logic [1:0]        presence_grade;
    } out_t;

    // Status of one transaction after the ring update.
    typedef struct packed {
        logic              accepted;
        logic              active;
        logic [DIST_W-1:0] latest;
    } stage_t;

endpackage

@@ rtl/core/uerp_ram.sv @@
module uerp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/uerp_judge.sv @@
module uerp_judge #(
    parameter int RING_DEPTH = uerp_pkg::RING_DEPTH_DEF
) (
    input  uerp_pkg::stage_t                                          ctrl,
    input  logic [uerp_pkg::DIST_W+$clog2(RING_DEPTH)-1:0]            sum,
    input  logic [uerp_pkg::DIST_W+$clog2(RING_DEPTH)-1:0]            prev_sum,
    input  uerp_pkg::cfg_t                                            cfg,
    output uerp_pkg::out_t                                            result
);

    localparam int SlotW    = $clog2(RING_DEPTH);
    localparam int SumW     = uerp_pkg::DIST_W + SlotW;
    localparam int AvgShift = SumW + SlotW;
    localparam int AvgProdW = SumW + AvgShift;
    localparam longint AvgMulL =
        ((longint'(1) << AvgShift) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int PresW    = SumW + 9;
    localparam int GradeW   = SumW + 8;

    logic [AvgProdW-1:0] avg_prod;
    logic [PresW-1:0]    pres_lhs;
    logic [PresW-1:0]    pres_rhs;
    logic                pres;
    logic [SumW-1:0]     diff;
    logic [GradeW-1:0]   diff_scaled;
    logic [GradeW-1:0]   strong_lim;
    logic [GradeW-1:0]   weak_lim;
    uerp_pkg::grade_t    grade;

    // Average: multiply by the rounded-up reciprocal of the ring depth.
    assign avg_prod = AvgProdW'(sum) * AvgProdW'(AvgMulL);

    // Presence: reference*depth must reach the sum raised by the presence percent.
    assign pres_lhs = PresW'(cfg.presence_threshold)
                    * PresW'(uerp_pkg::PCT_SCALE * RING_DEPTH);
    assign pres_rhs = PresW'(uerp_pkg::PCT_SCALE + int'(cfg.presence_percent))
                    * PresW'(sum);
    assign pres     = (sum == '0) ? (cfg.presence_threshold != '0)
                                  : (pres_lhs >= pres_rhs);

    // Grade from the relative change of the sum over the last stored item.
    assign diff        = (sum >= prev_sum) ? (sum - prev_sum) : (prev_sum - sum);
    assign diff_scaled = GradeW'(diff) * GradeW'(uerp_pkg::PCT_SCALE);
    assign strong_lim  = GradeW'(cfg.strong_percent) * GradeW'(prev_sum);
    assign weak_lim    = GradeW'(cfg.weak_percent) * GradeW'(prev_sum);

    always_comb begin
        if (diff_scaled > strong_lim) begin
            grade = uerp_pkg::GRADE_STRONG;
        end else if (diff_scaled < weak_lim) begin
            grade = uerp_pkg::GRADE_WEAK;
        end else begin
            grade = uerp_pkg::GRADE_MODERATE;
        end
    end

    // The average is always reported; everything else is zero while inactive.
    always_comb begin
        result              = '0;
        result.ring_average = avg_prod[AvgShift +: uerp_pkg::DIST_W];
        if (ctrl.active) begin
            result.accepted        = ctrl.accepted;
            result.latest_distance = ctrl.latest;
            result.obstacle        = (ctrl.latest <= cfg.obstacle_threshold);
            result.presence        = pres;
            result.presence_grade  = pres ? grade : uerp_pkg::GRADE_NONE;
        end
    end

endmodule

@@ rtl/core/ultrasonic_echo_range_presence.sv @@
// Ultrasonic echo ranger. Each input transaction carries one echo pulse width
// in microseconds and a completion flag; each produces exactly one result
// transaction. A valid width (block active, completion seen, nonzero and below
// the timeout) is converted to a distance in 1/16 inch and stored in a ring
// of the last RING_DEPTH distances kept in a small RAM with a running sum.
// Results report the newest distance, the truncated ring average, an obstacle
// flag and a graded presence flag. The block accepts one transaction per clock
// while the output is not stalled: the input register takes the transaction,
// then the ring update stage and the result register follow. The ring update
// is a read-modify-write of the running sum within its stage, which sets that
// rate. After reset the ring reads as all zero without any clearing pass, and
// configuration writes are taken on every cycle.
module ultrasonic_echo_range_presence #(
    parameter int RING_DEPTH = uerp_pkg::RING_DEPTH_DEF,
    parameter int WIDTH_BITS = uerp_pkg::WIDTH_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  uerp_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output uerp_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  uerp_pkg::cfg_index_t              cfg_index,
    input  logic [uerp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SlotW   = $clog2(RING_DEPTH);
    localparam int SumW    = uerp_pkg::DIST_W + SlotW;
    localparam int PulseW  = uerp_pkg::PULSE_W;
    localparam int UseW    = (WIDTH_BITS < PulseW) ? WIDTH_BITS : PulseW;
    localparam logic [PulseW-1:0] WidthMask = {PulseW{1'b1}} >> (PulseW - UseW);
    localparam int ScaledW = PulseW + 3;
    localparam int DistProdW = ScaledW + uerp_pkg::DIV_MUL_W;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(RING_DEPTH - 1);

    uerp_pkg::cfg_t   cfg_reg;

    logic             in_v_reg;
    uerp_pkg::in_t    in_data_reg;
    logic             mid_v_reg;
    uerp_pkg::stage_t mid_ctrl_reg;
    logic [SumW-1:0]  mid_sum_reg;
    logic [SumW-1:0]  mid_prev_reg;
    logic             out_v_reg;
    uerp_pkg::out_t   out_data_reg;
    uerp_pkg::out_t   judge_result;

    logic [SlotW-1:0]           write_slot_reg;
    logic [SlotW-1:0]           write_slot_next;
    logic                       filled_reg;
    logic [SumW-1:0]            sum_reg;
    logic [SumW-1:0]            prev_sum_reg;
    logic [uerp_pkg::DIST_W-1:0] latest_reg;

    logic                        out_free;
    logic                        mid_free;
    logic                        in_free;
    logic                        in_fire;
    logic [PulseW-1:0]           width;
    logic                        meas_ok;
    logic                        store;
    logic [ScaledW-1:0]          scaled;
    logic [DistProdW-1:0]        dist_prod;
    logic [uerp_pkg::DIST_W-1:0] new_dist;
    logic [uerp_pkg::DIST_W-1:0] ram_rdata;
    logic [uerp_pkg::DIST_W-1:0] old_dist;
    logic [SumW:0]               sum_wide;
    logic [SumW-1:0]             sum_new;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= uerp_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                uerp_pkg::REG_ACTIVE:             cfg_reg.active <= cfg_data[0];
                uerp_pkg::REG_TIMEOUT_US:         cfg_reg.timeout_us <= cfg_data;
                uerp_pkg::REG_DOUBLE_PATH:        cfg_reg.double_path <= cfg_data[0];
                uerp_pkg::REG_OBSTACLE_THRESHOLD: begin
                    cfg_reg.obstacle_threshold <= cfg_data[uerp_pkg::DIST_W-1:0];
                end
                uerp_pkg::REG_PRESENCE_THRESHOLD: begin
                    cfg_reg.presence_threshold <= cfg_data[uerp_pkg::DIST_W-1:0];
                end
                uerp_pkg::REG_PRESENCE_PERCENT: begin
                    cfg_reg.presence_percent <= cfg_data[uerp_pkg::PCT_W-1:0];
                end
                uerp_pkg::REG_STRONG_PERCENT: begin
                    cfg_reg.strong_percent <= cfg_data[uerp_pkg::PCT_W-1:0];
                end
                uerp_pkg::REG_WEAK_PERCENT: begin
                    cfg_reg.weak_percent <= cfg_data[uerp_pkg::PCT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Pipeline flow control: each stage moves when the one after it has room.
    assign out_free = !out_v_reg || m_ready;
    assign mid_free = !mid_v_reg || out_free;
    assign in_free  = !in_v_reg || mid_free;
    assign in_fire  = in_v_reg && mid_free;
    assign s_ready  = in_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_free) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_free) begin
            in_data_reg <= s_data;
        end
    end

    // Measurement check and distance conversion.
    assign width   = in_data_reg.pulse_width_us & WidthMask;
    assign meas_ok = cfg_reg.active && in_data_reg.wait_ok
                  && (width != '0) && (width < cfg_reg.timeout_us);
    assign store   = in_fire && meas_ok;

    // Scale by 4 (round trip) or 8 (one way), then divide by 37.
    // A 16-bit width never reaches the full-scale distance, so no clamp.
    assign scaled    = cfg_reg.double_path ? {width, 3'b000} : {1'b0, width, 2'b00};
    assign dist_prod = DistProdW'(scaled) * DistProdW'(uerp_pkg::DIV_MUL);
    assign new_dist  = dist_prod[uerp_pkg::DIV_SHIFT +: uerp_pkg::DIST_W];

    // Until the ring has wrapped once, the slot being replaced counts as zero.
    assign old_dist = filled_reg ? ram_rdata : '0;
    assign sum_wide = {1'b0, sum_reg} - (SumW+1)'(old_dist) + (SumW+1)'(new_dist);
    assign sum_new  = sum_wide[SumW-1:0];

    always_comb begin
        write_slot_next = write_slot_reg;
        if (store) begin
            write_slot_next = (write_slot_reg == LastSlot) ? '0 : write_slot_reg + 1'b1;
        end
    end

    // The read port prefetches the slot that the next stored item replaces.
    uerp_ram #(
        .WIDTH (uerp_pkg::DIST_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (store),
        .waddr (write_slot_reg),
        .wdata (new_dist),
        .raddr (write_slot_next),
        .rdata (ram_rdata)
    );

    // Ring bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            filled_reg     <= 1'b0;
            sum_reg        <= '0;
            prev_sum_reg   <= '0;
            latest_reg     <= '0;
        end else if (store) begin
            write_slot_reg <= write_slot_next;
            if (write_slot_reg == LastSlot) begin
                filled_reg <= 1'b1;
            end
            sum_reg      <= sum_new;
            prev_sum_reg <= sum_reg;
            latest_reg   <= new_dist;
        end
    end

    // Snapshot of the state after this transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_v_reg <= 1'b0;
        end else if (mid_free) begin
            mid_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mid_ctrl_reg.accepted <= meas_ok;
            mid_ctrl_reg.active   <= cfg_reg.active;
            mid_ctrl_reg.latest   <= meas_ok ? new_dist : latest_reg;
            mid_sum_reg           <= meas_ok ? sum_new : sum_reg;
            mid_prev_reg          <= meas_ok ? sum_reg : prev_sum_reg;
        end
    end

    uerp_judge #(
        .RING_DEPTH (RING_DEPTH)
    ) u_judge (
        .ctrl     (mid_ctrl_reg),
        .sum      (mid_sum_reg),
        .prev_sum (mid_prev_reg),
        .cfg      (cfg_reg),
        .result   (judge_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg <= mid_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_v_reg && out_free) begin
            out_data_reg <= judge_result;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(write_slot_reg) < RING_DEPTH)
        else $error("ring write slot outside the ring");

    a_prev_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        store |=> prev_sum_reg == $past(sum_reg))
        else $error("previous sum not saved on a stored measurement");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_v_reg |-> s_ready)
        else $error("input stalled while the result register is empty");

    a_inactive_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !cfg_reg.active |=> $stable(sum_reg) && $stable(write_slot_reg))
        else $error("ring changed while the sensor is inactive");

    a_fill_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(filled_reg) |-> write_slot_reg == '0)
        else $error("ring marked full without a wrap of the write slot");
`endif

endmodule
